>>> hdl/sefr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefr_pkg: shared types and constants for the STX/ETX frame receiver
// Framing bytes, result kinds, error causes and the result record.
// ----------------------------------------------------------------------------
package sefr_pkg;

    localparam logic [7:0] START_BYTE      = 8'h02;
    localparam logic [7:0] END_BYTE        = 8'h03;
    localparam logic [7:0] ACK_BYTE        = 8'h06;
    localparam logic [7:0] NAK_BYTE        = 8'h15;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'hFF;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_NAK     = 2'd2;

    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_LEN  = 2'd1;
    localparam logic [1:0] CAUSE_CHK  = 2'd2;
    localparam logic [1:0] CAUSE_END  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] response_byte;
        logic [1:0] error_cause;
        logic [7:0] frame_length;
    } result_t;

endpackage

>>> hdl/stx_etx_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_unit: STX/ETX deframer with XOR checksum
// Results are registered in the result register, or in the skid register on a stall.
// Throughput: one byte per cycle while the skid register is empty; the frame
// state update and XOR finish in the cycle of acceptance, and a two-entry
// output buffer (result register plus skid register) keeps input flowing while a result waits.
// Reset: hunting for STX, max_payload 255, output buffer empty.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver_unit
    import sefr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] response_byte,
    output logic [1:0] error_cause,
    output logic [7:0] frame_length
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CHK  = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] frame_len_reg, frame_len_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] max_payload_reg;

    result_t    res;
    logic       has_res;
    result_t    out_reg, skid_reg;
    logic       out_valid_reg, skid_valid_reg;

    logic       in_fire, push, pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign push      = in_fire && has_res;
    assign pop       = out_valid_reg && out_ready;

    function automatic result_t verdict(input logic [1:0] k, input logic [7:0] resp,
                                        input logic [1:0] cause, input logic [7:0] flen);
        result_t r;
        r.kind          = k;
        r.payload_byte  = 8'd0;
        r.payload_index = 8'd0;
        r.response_byte = resp;
        r.error_cause   = cause;
        r.frame_length  = flen;
        return r;
    endfunction

    // frame state update and result for the byte at the input
    always_comb
    begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        byte_count_next = byte_count_reg;
        xor_next        = xor_reg;
        has_res         = 1'b0;
        res             = verdict(KIND_ACK, ACK_BYTE, CAUSE_NONE, frame_len_reg);
        unique case (phase_reg)
            PH_LEN:
            begin
                frame_len_next = rx_byte;
                if (rx_byte > max_payload_reg)
                begin
                    phase_next = PH_HUNT;
                    has_res    = 1'b1;
                    res        = verdict(KIND_NAK, NAK_BYTE, CAUSE_LEN, rx_byte);
                end
                else
                begin
                    xor_next        = xor_reg ^ rx_byte;
                    byte_count_next = 8'd0;
                    phase_next      = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
                end
            end
            PH_DATA:
            begin
                xor_next        = xor_reg ^ rx_byte;
                byte_count_next = byte_count_reg + 8'd1;
                if (byte_count_next == frame_len_reg)
                begin
                    phase_next = PH_CHK;
                end
                has_res           = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = rx_byte;
                res.payload_index = byte_count_reg;
                res.response_byte = 8'd0;
                res.error_cause   = CAUSE_NONE;
                res.frame_length  = frame_len_reg;
            end
            PH_CHK:
            begin
                if (rx_byte != xor_reg)
                begin
                    phase_next = PH_HUNT;
                    has_res    = 1'b1;
                    res        = verdict(KIND_NAK, NAK_BYTE, CAUSE_CHK, frame_len_reg);
                end
                else
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                phase_next = PH_HUNT;
                has_res    = 1'b1;
                if (rx_byte != END_BYTE)
                begin
                    res = verdict(KIND_NAK, NAK_BYTE, CAUSE_END, frame_len_reg);
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (rx_byte == START_BYTE)
                begin
                    xor_next        = START_BYTE;
                    byte_count_next = 8'd0;
                    phase_next      = PH_LEN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            frame_len_reg   <= 8'd0;
            byte_count_reg  <= 8'd0;
            xor_reg         <= START_BYTE;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_payload_reg <= cfg_data;
            end
            if (in_fire)
            begin
                phase_reg      <= phase_next;
                frame_len_reg  <= frame_len_next;
                byte_count_reg <= byte_count_next;
                xor_reg        <= xor_next;
            end
        end
    end

    // output register with skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= push;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= res;
                end
            end
            else if (push)
            begin
                out_reg <= res;
            end
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign payload_index = out_reg.payload_index;
    assign response_byte = out_reg.response_byte;
    assign error_cause   = out_reg.error_cause;
    assign frame_length  = out_reg.frame_length;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_verdict_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind != KIND_PAYLOAD) |->
        (out_reg.payload_byte == 8'd0 && out_reg.payload_index == 8'd0))
        else $error("verdict transaction carries payload data");

    a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (frame_len_reg != 8'd0 &&
        byte_count_reg < frame_len_reg))
        else $error("payload phase with count past frame length");

    a_nak_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_NAK) |->
        (out_reg.error_cause != CAUSE_NONE && out_reg.response_byte == NAK_BYTE))
        else $error("NAK without cause");
`endif

endmodule
